// ----- hw/rtl/brl_pkg.sv -----
// Shared types and constants for the Bresenham line rasterizer.
// Depends on nothing; every other file of the block uses it by scoped names.

package brl_pkg;

   localparam int COORD_BITS = 12;
   localparam int REG_BITS   = 13;
   localparam int INDEX_BITS = 24;
   localparam int ERR_BITS   = COORD_BITS + 2;
   localparam int CMP_BITS   = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
   localparam int SUM_BITS   = (COORD_BITS + REG_BITS >= INDEX_BITS) ?
                               (COORD_BITS + REG_BITS) : INDEX_BITS;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [REG_BITS-1:0] FRAME_WIDTH_RESET  = REG_BITS'(1024);
   localparam logic [REG_BITS-1:0] FRAME_HEIGHT_RESET = REG_BITS'(768);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = CSR_INDEX_BITS'(1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef struct packed {
      logic                         req_type;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic        [INDEX_BITS-1:0] pixel_index;
      logic                         in_frame;
      logic                         last;
   } rsp_payload_type;

   // Classified command passed from the front end to the draw engine.
   typedef struct packed {
      op_type                       op;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic        [COORD_BITS-1:0] delta_x;
      logic        [COORD_BITS-1:0] delta_y;
      logic                         step_x_negative;
      logic                         step_y_negative;
      logic signed [ERR_BITS-1:0]   error_init;
      logic                         nonzero;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// Bresenham line rasterizer: requests pass the queue, then the result register.
// Throughput one item per cycle unless stalled; one error update per step.
// Front end and draw engine are split by a two-entry command queue.
// Synchronous active-high reset empties the queue, drops any line, clears
// the result valid flag and sets frame width 1024, height 768.
// Depends on brl_pkg, brl_front, brl_queue and brl_back.

module bresenham_line_rasterizer (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  brl_pkg::req_payload_type              req_data,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output brl_pkg::rsp_payload_type              rsp_data,
   // register write port
   input  logic                                  csr_we,
   input  logic [brl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [brl_pkg::REG_BITS-1:0]          csr_wdata
);

   logic [brl_pkg::REG_BITS-1:0] frame_width_ff, frame_width_in;
   logic [brl_pkg::REG_BITS-1:0] frame_height_ff, frame_height_in;

   logic                    queue_full;
   logic                    push;
   brl_pkg::cmd_type        push_cmd;
   logic                    pop;
   brl_pkg::queue_head_type head;

   // Register writes; an index beyond the list is dropped.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            brl_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wdata;
            brl_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= brl_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= brl_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Classify each request transfer and precompute the load setup.
   brl_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Hold commands so either side can stall on its own.
   brl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   // Advance the line and register one pixel per step.
   brl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

// ----- hw/rtl/brl_front.sv -----
// Front end of the line rasterizer: accepts request transfers and classifies them.
// Depends on brl_pkg for the request payload and command types.

module brl_front (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  brl_pkg::req_payload_type req_data,
   input  logic                     queue_full,
   output logic                     push,
   output brl_pkg::cmd_type         push_cmd
);

   logic signed [brl_pkg::COORD_BITS:0] diff_x;
   logic signed [brl_pkg::COORD_BITS:0] diff_y;
   logic        [brl_pkg::COORD_BITS:0] abs_x;
   logic        [brl_pkg::COORD_BITS:0] abs_y;
   logic        [brl_pkg::COORD_BITS-1:0] half_x;
   logic        [brl_pkg::COORD_BITS-1:0] half_y;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      diff_x = (brl_pkg::COORD_BITS+1)'(req_data.end_x) -
               (brl_pkg::COORD_BITS+1)'(req_data.start_x);
      diff_y = (brl_pkg::COORD_BITS+1)'(req_data.end_y) -
               (brl_pkg::COORD_BITS+1)'(req_data.start_y);
      abs_x  = diff_x[brl_pkg::COORD_BITS] ? -diff_x : diff_x;
      abs_y  = diff_y[brl_pkg::COORD_BITS] ? -diff_y : diff_y;
      half_x = abs_x[brl_pkg::COORD_BITS:1];
      half_y = abs_y[brl_pkg::COORD_BITS:1];

      push_cmd.op = (req_data.req_type == brl_pkg::OP_STEP) ?
                    brl_pkg::OP_STEP : brl_pkg::OP_LOAD;
      push_cmd.start_x = req_data.start_x;
      push_cmd.start_y = req_data.start_y;
      push_cmd.end_x   = req_data.end_x;
      push_cmd.end_y   = req_data.end_y;
      push_cmd.delta_x = abs_x[brl_pkg::COORD_BITS-1:0];
      push_cmd.delta_y = abs_y[brl_pkg::COORD_BITS-1:0];
      push_cmd.step_x_negative = !(req_data.start_x < req_data.end_x);
      push_cmd.step_y_negative = !(req_data.start_y < req_data.end_y);
      // Error starts at half the major delta, negative when y dominates or ties.
      if (abs_x > abs_y) begin
         push_cmd.error_init = signed'(brl_pkg::ERR_BITS'(half_x));
      end else begin
         push_cmd.error_init = -signed'(brl_pkg::ERR_BITS'(half_y));
      end
      push_cmd.nonzero = (req_data.start_x != req_data.end_x) ||
                         (req_data.start_y != req_data.end_y);
   end

endmodule

// ----- hw/rtl/brl_queue.sv -----
// Two-entry command queue between the front end and the draw engine.
// Depends on brl_pkg for the command and queue head types.

module brl_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  brl_pkg::cmd_type        push_cmd,
   output logic                    full,
   input  logic                    pop,
   output brl_pkg::queue_head_type head
);

   brl_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/brl_back.sv -----
// Draw engine: holds the line state, runs one Bresenham step per step
// command on an active line and registers the pixel result.
// Depends on brl_pkg for the command, queue head and result types.

module brl_back (
   input  logic                           clock,
   input  logic                           reset,
   input  brl_pkg::queue_head_type        head,
   output logic                           pop,
   input  logic [brl_pkg::REG_BITS-1:0]   frame_width,
   input  logic [brl_pkg::REG_BITS-1:0]   frame_height,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output brl_pkg::rsp_payload_type       rsp_data
);

   localparam int CB = brl_pkg::COORD_BITS;
   localparam int EB = brl_pkg::ERR_BITS;

   logic signed [CB-1:0] cur_x_ff, cur_x_in;
   logic signed [CB-1:0] cur_y_ff, cur_y_in;
   logic signed [CB-1:0] tgt_x_ff, tgt_x_in;
   logic signed [CB-1:0] tgt_y_ff, tgt_y_in;
   logic        [CB-1:0] dx_ff, dx_in;
   logic        [CB-1:0] dy_ff, dy_in;
   logic                 neg_x_ff, neg_x_in;
   logic                 neg_y_ff, neg_y_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   brl_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 is_load;
   logic                 emit;
   logic signed [EB-1:0] dx_ext;
   logic signed [EB-1:0] dy_ext;
   logic                 take_x;
   logic                 take_y;
   logic signed [CB-1:0] next_x;
   logic signed [CB-1:0] next_y;
   logic                 in_bounds;
   logic [brl_pkg::CMP_BITS-1:0] px_cmp;
   logic [brl_pkg::CMP_BITS-1:0] py_cmp;
   logic [brl_pkg::SUM_BITS-1:0] idx_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_load   = (head.cmd.op == brl_pkg::OP_LOAD);
   assign pop       = head.valid && (is_load || out_free);
   assign emit      = pop && !is_load && active_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // One Bresenham step from the current point.
   always_comb begin
      dx_ext = signed'(EB'(dx_ff));
      dy_ext = signed'(EB'(dy_ff));
      take_x = (err_ff > -dx_ext);
      take_y = (err_ff < dy_ext);
      next_x = cur_x_ff;
      next_y = cur_y_ff;
      if (take_x) begin
         next_x = neg_x_ff ? cur_x_ff - CB'(1) : cur_x_ff + CB'(1);
      end
      if (take_y) begin
         next_y = neg_y_ff ? cur_y_ff - CB'(1) : cur_y_ff + CB'(1);
      end
   end

   // Pixel result for the current point.
   always_comb begin
      px_cmp = brl_pkg::CMP_BITS'(unsigned'(cur_x_ff));
      py_cmp = brl_pkg::CMP_BITS'(unsigned'(cur_y_ff));
      in_bounds = !cur_x_ff[CB-1] && !cur_y_ff[CB-1] &&
                  (px_cmp < brl_pkg::CMP_BITS'(frame_width)) &&
                  (py_cmp < brl_pkg::CMP_BITS'(frame_height));
      idx_sum = brl_pkg::SUM_BITS'(unsigned'(cur_y_ff)) *
                brl_pkg::SUM_BITS'(frame_width) +
                brl_pkg::SUM_BITS'(unsigned'(cur_x_ff));
      rsp_data_in.pixel_x     = cur_x_ff;
      rsp_data_in.pixel_y     = cur_y_ff;
      rsp_data_in.pixel_index = in_bounds ? idx_sum[brl_pkg::INDEX_BITS-1:0] :
                                            brl_pkg::INDEX_BITS'(0);
      rsp_data_in.in_frame    = in_bounds;
      rsp_data_in.last        = (next_x == tgt_x_ff) && (next_y == tgt_y_ff);
   end

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      neg_x_in  = neg_x_ff;
      neg_y_in  = neg_y_ff;
      err_in    = err_ff;
      active_in = active_ff;
      if (pop && is_load) begin
         cur_x_in  = head.cmd.start_x;
         cur_y_in  = head.cmd.start_y;
         tgt_x_in  = head.cmd.end_x;
         tgt_y_in  = head.cmd.end_y;
         dx_in     = head.cmd.delta_x;
         dy_in     = head.cmd.delta_y;
         neg_x_in  = head.cmd.step_x_negative;
         neg_y_in  = head.cmd.step_y_negative;
         err_in    = head.cmd.error_init;
         active_in = head.cmd.nonzero;
      end else if (emit) begin
         cur_x_in  = next_x;
         cur_y_in  = next_y;
         err_in    = err_ff - (take_x ? dy_ext : EB'(0)) + (take_y ? dx_ext : EB'(0));
         active_in = !rsp_data_in.last;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      neg_x_ff <= neg_x_in;
      neg_y_ff <= neg_y_in;
      err_ff   <= err_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for bresenham_line_rasterizer: a built-in line predictor
// scores every pixel that comes out while random line jobs stream in.
// Depends on brl_pkg and the bresenham_line_rasterizer RTL only.

module tb_top;
   import brl_pkg::*;

   localparam int IDLE_PERCENT     = 6;     // chance per cycle that a side idles
   localparam int SETTLE_CYCLES    = 8;     // margin so the pipeline runs dry
   localparam int HOLD_CYCLES      = 120;   // long receiver stall, fills the queue
   localparam int STALL_LIMIT      = 2000;  // cycles without any transfer
   localparam int RANDOM_PER_PHASE = 215;   // loads and drawn steps per setting
   localparam int REQ_BITS         = $bits(req_payload_type);

   // Indexes past the register list; writes there must be dropped.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = CSR_INDEX_BITS'(3);

   // Line predictor plus the queue of pixels still owed by the block.
   class pixel_scoreboard;
      logic [REG_BITS-1:0]          width;
      logic [REG_BITS-1:0]          height;
      logic signed [COORD_BITS-1:0] cur_x, cur_y, tgt_x, tgt_y;
      logic [COORD_BITS-1:0]        dx, dy;
      logic                         x_back, y_back;
      logic signed [COORD_BITS:0]   err;
      logic                         drawing;
      rsp_payload_type              owed_pixels[$];
      int                           errors, loads, pixels, ignored_steps;

      function new();
         width   = FRAME_WIDTH_RESET;
         height  = FRAME_HEIGHT_RESET;
         cur_x   = '0;
         cur_y   = '0;
         tgt_x   = '0;
         tgt_y   = '0;
         dx      = '0;
         dy      = '0;
         x_back  = 1'b0;
         y_back  = 1'b0;
         err     = '0;
         drawing = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [REG_BITS-1:0] value);
         case (index)
            CSR_FRAME_WIDTH: begin
               width = value;
            end
            CSR_FRAME_HEIGHT: begin
               height = value;
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction

      // Update the line state for one accepted request; return 1 when it owes a pixel.
      function bit note_request(req_payload_type item);
         int              x0, y0, x1, y1, ddx, ddy, px, py, e, next_e;
         longint          spot;
         bit              in_bounds;
         rsp_payload_type pix;
         if (item.req_type == OP_LOAD) begin
            x0      = int'($signed(item.start_x));
            y0      = int'($signed(item.start_y));
            x1      = int'($signed(item.end_x));
            y1      = int'($signed(item.end_y));
            ddx     = (x1 > x0) ? x1 - x0 : x0 - x1;
            ddy     = (y1 > y0) ? y1 - y0 : y0 - y1;
            cur_x   = item.start_x;
            cur_y   = item.start_y;
            tgt_x   = item.end_x;
            tgt_y   = item.end_y;
            dx      = COORD_BITS'(ddx);
            dy      = COORD_BITS'(ddy);
            x_back  = !(x0 < x1);
            y_back  = !(y0 < y1);
            e       = (ddx > ddy) ? ddx / 2 : -(ddy / 2);
            err     = (COORD_BITS+1)'(e);
            drawing = (x0 != x1) || (y0 != y1);
            loads++;
            return 1'b0;
         end
         if (!drawing) begin
            ignored_steps++;
            return 1'b0;
         end
         px     = int'(cur_x);
         py     = int'(cur_y);
         ddx    = int'(dx);
         ddy    = int'(dy);
         e      = int'(err);
         next_e = e;
         // Both moves test the error value from before this step.
         if (e > -ddx) begin
            next_e -= ddy;
            cur_x   = COORD_BITS'(px + (x_back ? -1 : 1));
         end
         if (e < ddy) begin
            next_e += ddx;
            cur_y   = COORD_BITS'(py + (y_back ? -1 : 1));
         end
         err = (COORD_BITS+1)'(next_e);
         if (cur_x == tgt_x && cur_y == tgt_y)
            drawing = 1'b0;
         in_bounds = px >= 0 && py >= 0 && px < int'(width) && py < int'(height);
         spot      = in_bounds ? longint'(px) + longint'(py) * longint'(width) : 64'sd0;
         pix.pixel_x     = COORD_BITS'(px);
         pix.pixel_y     = COORD_BITS'(py);
         pix.pixel_index = INDEX_BITS'(spot);
         pix.in_frame    = in_bounds;
         pix.last        = !drawing;
         owed_pixels.push_back(pix);
         return 1'b1;
      endfunction

      task report_mismatch(string what);
         $display("ERROR pixel %0d: %s", pixels, what);
         errors++;
      endtask

      task check_pixel(rsp_payload_type got);
         rsp_payload_type want;
         if (owed_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.pixel_x, got.pixel_y));
            return;
         end
         want = owed_pixels.pop_front();
         pixels++;
         if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
         if (got.pixel_index !== want.pixel_index)
            report_mismatch($sformatf("pixel_index %0d, want %0d",
                                      got.pixel_index, want.pixel_index));
         if (got.in_frame !== want.in_frame)
            report_mismatch($sformatf("in_frame %b, want %b", got.in_frame, want.in_frame));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_payload_type           req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_payload_type           rsp_data;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0]       csr_wdata;

   pixel_scoreboard sb;
   int              counted_items;    // loads plus steps that drew a pixel
   bit              steady;           // no idling on either side
   bit              squeeze_request;  // ask the receiver for one long stall

   bresenham_line_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int fit_coord(int v);
      if (v < -2048)
         return -2048;
      if (v > 2047)
         return 2047;
      return v;
   endfunction

   function automatic req_payload_type make_load(int x0, int y0, int x1, int y1);
      req_payload_type item;
      item.req_type = OP_LOAD;
      item.start_x  = COORD_BITS'(x0);
      item.start_y  = COORD_BITS'(y0);
      item.end_x    = COORD_BITS'(x1);
      item.end_y    = COORD_BITS'(y1);
      return item;
   endfunction

   // Step requests carry junk in the coordinate fields; the block must ignore it.
   function automatic req_payload_type step_item();
      req_payload_type item;
      item          = REQ_BITS'({$urandom, $urandom});
      item.req_type = OP_STEP;
      return item;
   endfunction

   // Offer one request, with a random gap ahead of it. Decide the transfer
   // at the falling edge, where valid and ready are settled, then return at
   // the rising edge that completes it, so the caller drives the next value
   // in that same step.
   task automatic send_item(req_payload_type item);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_ready);
      if (sb.note_request(item) || item.req_type == OP_LOAD)
         counted_items++;
      @(posedge clock);
   endtask

   // Drop valid and wait until every owed pixel has arrived, then let the
   // pipeline run dry in case a step with nothing to draw is still inside.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Hold csr_we high across back-to-back writes; the caller lowers it.
   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] index, logic [REG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_register(index, value);
      @(posedge clock);
   endtask

   // Stream well-formed line jobs with random content, plus some raw noise.
   task automatic run_random(int quota);
      int              goal, r, x0, y0, x1, y1, reach, steps, ax, ay;
      req_payload_type noise;
      goal = counted_items + quota;
      while (counted_items < goal) begin
         r = $urandom_range(99);
         if (r < 6) begin
            noise = REQ_BITS'({$urandom, $urandom});
            send_item(noise);
         end else begin
            // Pick the start: anywhere, near the origin, or across the frame edge.
            r = $urandom_range(2);
            if (r == 0) begin
               x0 = int'($urandom_range(4095)) - 2048;
               y0 = int'($urandom_range(4095)) - 2048;
            end else if (r == 1 || sb.width > 2040 || sb.height > 2040 ||
                         sb.width == 0 || sb.height == 0) begin
               x0 = int'($urandom_range(48)) - 8;
               y0 = int'($urandom_range(48)) - 8;
            end else begin
               x0 = int'(sb.width) - 3 + int'($urandom_range(5));
               y0 = int'(sb.height) - 3 + int'($urandom_range(5));
            end
            x0    = fit_coord(x0);
            y0    = fit_coord(y0);
            reach = ($urandom_range(99) < 5) ? 300 : 12;
            x1    = fit_coord(x0 + int'($urandom_range(2 * reach)) - reach);
            y1    = fit_coord(y0 + int'($urandom_range(2 * reach)) - reach);
            send_item(make_load(x0, y0, x1, y1));
            ax    = (x1 > x0) ? x1 - x0 : x0 - x1;
            ay    = (y1 > y0) ? y1 - y0 : y0 - y1;
            steps = (ax > ay) ? ax : ay;
            // Mostly run the line out (sometimes past its end); else abandon it.
            if ($urandom_range(99) < 20)
               steps = $urandom_range(steps);
            else
               steps += $urandom_range(2);
            repeat (steps) send_item(step_item());
         end
      end
   endtask

   // Result side: pick ready at the rising edge, score a transfer at the falling edge.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze_request) begin
            hold_left       = HOLD_CYCLES;
            squeeze_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
         @(negedge clock);
         if (rsp_valid && rsp_ready)
            sb.check_pixel(rsp_data);
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transfer for %0d cycles, %0d pixels owed", quiet, sb.pending());
      $display("bresenham_line_rasterizer: mismatch");
      $finish;
   end

   initial begin
      logic [REG_BITS-1:0] w, h;
      sb              = new();
      counted_items   = 0;
      steady          = 1'b0;
      squeeze_request = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed lines under the reset frame of 1024 x 768.
      send_item(step_item());                          // step with no line: drop it
      send_item(make_load(0, 0, 0, 0));                // zero-length line
      send_item(step_item());
      send_item(make_load(2047, -2048, -2048, 2047));  // corner to corner ...
      repeat (2) send_item(step_item());
      send_item(make_load(-2048, 2047, 2047, -2048));  // ... replaced mid-line
      send_item(step_item());
      send_item(make_load(1021, 765, 1026, 767));      // x-major, crosses right edge
      repeat (5) send_item(step_item());
      send_item(make_load(0, 766, 1, 769));            // y-major, crosses bottom edge
      repeat (3) send_item(step_item());
      send_item(make_load(5, 5, 8, 8));                // diagonal, one step past the end
      repeat (4) send_item(step_item());
      drain();

      // Random phases, one frame setting each; registers change only when idle.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin w = 13'd1;    h = 13'd1;    end
            1: begin w = 13'd4096; h = 13'd4096; end
            2: begin w = 13'd0;    h = 13'd4096; end
            3: begin w = 13'd8191; h = 13'd0;    end
            4: begin w = 13'd640;  h = 13'd480;  end
            default: begin
               w = REG_BITS'($urandom_range(1, 4096));
               h = REG_BITS'($urandom_range(1, 4096));
            end
         endcase
         write_csr(CSR_FRAME_WIDTH, w);
         write_csr(CSR_FRAME_HEIGHT, h);
         if (p == 2) begin
            // Writes past the register list must leave the frame alone.
            write_csr(CSR_UNUSED_LO, REG_BITS'($urandom));
            write_csr(CSR_UNUSED_HI, REG_BITS'($urandom));
         end
         csr_we <= 1'b0;
         steady = (p == 1);
         if (p == 3)
            squeeze_request = 1'b1;
         run_random(RANDOM_PER_PHASE);
         drain();
      end
      steady = 1'b0;

      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pending()));
      $display("covered %0d line loads and %0d pixels over 7 frame settings;",
               sb.loads, sb.pixels);
      $display("%0d steps hit no active line, %0d mismatches", sb.ignored_steps, sb.errors);
      if (sb.errors == 0)
         $display("bresenham_line_rasterizer: match");
      else
         $display("bresenham_line_rasterizer: mismatch");
      $finish;
   end

endmodule
